[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros used by the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mavg_pkg.sv]
// ----------------------------------------------------------------------------
// mavg_pkg
// shared constants for the moving average filter
// ----------------------------------------------------------------------------
package mavg_pkg;

    localparam int MAX_WINDOW_DEF  = 128;
    localparam int SAMPLE_BITS_DEF = 16;

    // window register
    localparam int              WIN_BITS     = 8;
    localparam logic [WIN_BITS-1:0] WINDOW_RESET = 8'd5;

endpackage

[hdl/mavg_if.sv]
// ----------------------------------------------------------------------------
// mavg channel interfaces
// valid/ready channels for samples, averages and the window register
// ----------------------------------------------------------------------------
interface mavg_sample_if #(
    parameter int W = 16
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mavg_average_if #(
    parameter int W = 16
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

interface mavg_cfg_if
    import mavg_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [WIN_BITS-1:0] window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

[hdl/mavg_div.sv]
// ----------------------------------------------------------------------------
// mavg_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mavg_div #(
    parameter int DIVIDEND_BITS = 23,
    parameter int DIVISOR_BITS  = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient
);

    localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg,  busy_next;
    logic                     done_reg,  done_next;
    logic [STEP_BITS-1:0]     step_reg,  step_next;
    logic [DIVIDEND_BITS-1:0] quo_reg,   quo_next;
    logic [DIVISOR_BITS-1:0]  rem_reg,   rem_next;
    logic [DIVISOR_BITS-1:0]  dsr_reg,   dsr_next;
    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;

    // partial remainder with the next dividend bit shifted in
    assign trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_BITS'(DIVIDEND_BITS);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[DIVISOR_BITS-1:0];
                quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_BITS-1:0];
                quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/moving_average_filter_core.sv]
// ----------------------------------------------------------------------------
// moving_average_filter_core
// Running mean of the last window_length signed samples, truncated toward
// zero; while the window fills the divisor is the number of samples seen.
// One sample is in flight at a time; a new one is taken only once the block
// is back in idle: the accepting edge reads the oldest entry from the sample
// memory, the update step updates the sum and writes the new sample back,
// the load step starts the divider, the divide step runs the one-bit-per-cycle
// divider until it is done, the output step loads the output register, and
// the block returns to idle to take the next word. An average still waiting
// when the next one is ready holds the block in its last step until it is
// taken. Writing window_length clears the sum, the position and the fill count
// at once; the fill count marks which memory entries hold live samples, so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module moving_average_filter_core
    import mavg_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    mavg_cfg_if.sink       cfg,
    mavg_sample_if.sink    samples,
    mavg_average_if.source averages
);

    localparam int POS_BITS = $clog2(MAX_WINDOW);
    localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CMP_BITS = (CNT_BITS > WIN_BITS) ? CNT_BITS : WIN_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                    state_reg,   state_next;
    logic [WIN_BITS-1:0]           window_reg,  window_next;
    logic [POS_BITS-1:0]           pos_reg,     pos_next;
    logic [CNT_BITS-1:0]           cnt_reg,     cnt_next;
    logic signed [SUM_BITS-1:0]    sum_reg,     sum_next;
    logic                          full_reg,    full_next;
    logic                          neg_reg,     neg_next;
    logic                          oval_reg,    oval_next;
    logic signed [SAMPLE_BITS-1:0] odata_reg,   odata_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

    logic [CMP_BITS-1:0]  win_ext;
    logic [CNT_BITS-1:0]  win_eff;
    logic [CNT_BITS-1:0]  pos_inc;
    logic                 in_acc;
    logic                 cfg_acc;
    logic                 div_start;
    logic                 div_done;
    logic [SUM_BITS-1:0]  div_quo;
    logic [SUM_BITS-1:0]  sum_mag;
    logic [SUM_BITS-1:0]  res_full;
    logic signed [SUM_BITS-1:0] old_ext;

    assign cfg.ready     = (state_reg == ST_IDLE);
    assign samples.ready = (state_reg == ST_IDLE) && !cfg.valid;
    assign cfg_acc       = cfg.valid && cfg.ready;
    assign in_acc        = samples.valid && samples.ready;

    // zero means one, above the store depth saturates
    assign win_ext = CMP_BITS'(window_reg);
    always_comb
    begin
        if (window_reg == '0)
            win_eff = CNT_BITS'(1);
        else if (win_ext > CMP_BITS'(MAX_WINDOW))
            win_eff = CNT_BITS'(MAX_WINDOW);
        else
            win_eff = CNT_BITS'(win_ext);
    end

    assign pos_inc   = CNT_BITS'(pos_reg) + 1'b1;
    // entry only counts once the window has wrapped
    assign old_ext   = full_reg ? SUM_BITS'(rd_data_reg) : '0;
    assign sum_mag   = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);
    assign res_full  = neg_reg ? (~div_quo + 1'b1) : div_quo;
    assign div_start = (state_reg == ST_LOAD);

    always_comb
    begin
        state_next  = state_reg;
        window_next = window_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        full_next   = full_reg;
        neg_next    = neg_reg;
        oval_next   = oval_reg;
        odata_next  = odata_reg;
        if (oval_reg && averages.ready)
            oval_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_acc)
                begin
                    window_next = cfg.window_length;
                    pos_next    = '0;
                    cnt_next    = '0;
                    sum_next    = '0;
                end
                else if (in_acc)
                begin
                    full_next  = (cnt_reg == win_eff);
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                sum_next = sum_reg - old_ext + SUM_BITS'(sample_reg);
                if (pos_inc >= win_eff)
                    pos_next = '0;
                else
                    pos_next = pos_inc[POS_BITS-1:0];
                if (!full_reg)
                    cnt_next = cnt_reg + 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                neg_next   = sum_reg[SUM_BITS-1];
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!oval_reg || averages.ready)
                begin
                    oval_next  = 1'b1;
                    odata_next = SAMPLE_BITS'(res_full);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            window_reg <= WINDOW_RESET;
            pos_reg    <= '0;
            cnt_reg    <= '0;
            sum_reg    <= '0;
            full_reg   <= 1'b0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            window_reg <= window_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            sum_reg    <= sum_next;
            full_reg   <= full_next;
            oval_reg   <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        odata_reg <= odata_next;
        if (in_acc)
            sample_reg <= samples.sample;
    end

    // read happens at accept and the write in the cycle after, never together
    always_ff @(posedge clk)
    begin
        if (in_acc)
            rd_data_reg <= mem[pos_reg];
        if (state_reg == ST_UPD)
            mem[pos_reg] <= sample_reg;
    end

    mavg_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (CNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign averages.valid   = oval_reg;
    assign averages.average = odata_reg;

endmodule

[hdl/mavg_core_chk.sv]
// ----------------------------------------------------------------------------
// mavg_core_chk
// port-level checks on the moving average filter, bound to the filter core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mavg_core_chk
    import mavg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] out_average,
    input logic                   cfg_valid,
    input logic                   cfg_ready
);

    // a stalled word keeps its valid
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "average dropped")
    // a stalled word keeps its value
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_average), "average changed")
    // one sample at a time: right after an accept neither the sample nor the window port is ready
    `ASSERT_NEXT(a_one_inflight, clk, rst_n, in_valid && in_ready, !in_ready && !cfg_ready, "second word taken while busy")
    // a window write and a sample never land on the same edge
    `ASSERT_IMP(a_cfg_excl, clk, rst_n, cfg_valid && cfg_ready, !(in_valid && in_ready), "window write raced a sample")

endmodule

bind moving_average_filter_core mavg_core_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mavg_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (samples.valid),
    .in_ready    (samples.ready),
    .out_valid   (averages.valid),
    .out_ready   (averages.ready),
    .out_average (averages.average),
    .cfg_valid   (cfg.valid),
    .cfg_ready   (cfg.ready)
);
